@@ sv/pmsfp_pkg.sv @@
// Shared constants and types for the particulate sensor frame parser.
package pmsfp_pkg;

    localparam logic [7:0]  HDR_FIRST             = 8'h42;
    localparam logic [7:0]  HDR_SECOND            = 8'h4D;
    localparam logic [31:0] REPORT_INTERVAL_RESET = 32'd15000;
    localparam int          WORD_INDEX_W          = 4;
    localparam int          WORD_W                = 16;

    // One queued report: which bank of the word store holds its words.
    typedef struct packed {
        logic bank;
    } report_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/pmsfp_if.sv @@
// Channel interfaces: received bytes, word results and the interval register write.
interface pmsfp_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] tick_now;

    modport source (output valid, output rx_byte, output tick_now, input ready);
    modport sink (input valid, input rx_byte, input tick_now, output ready);
endinterface

interface pmsfp_word_if;
    logic                                 valid;
    logic                                 ready;
    logic [pmsfp_pkg::WORD_INDEX_W-1:0]   word_index;
    logic [pmsfp_pkg::WORD_W-1:0]         word_value;
    logic                                 last_word;

    modport source (output valid, output word_index, output word_value,
                    output last_word, input ready);
    modport sink (input valid, input word_index, input word_value,
                  input last_word, output ready);
endinterface

interface pmsfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] report_interval;

    modport source (output valid, output report_interval, input ready);
    modport sink (input valid, input report_interval, output ready);
endinterface

@@ sv/pm_sensor_frame_parser_unit.sv @@
// Top level of the particulate sensor frame parser.
//
//  channel  dir  payload                         transfer when
//  rx       in   rx_byte[7:0], tick_now[31:0]    rx.valid && rx.ready
//  words    out  word_index[3:0],                words.valid && words.ready
//                word_value[15:0], last_word
//  cfg      in   report_interval[31:0]           cfg.valid && cfg.ready (ready tied high)
//
//  A byte is taken every cycle while fewer than two reports are waiting; a full
//  report queue holds rx.ready low until the emitter frees a store bank.
//  Each reported frame leaves as DATA_WORDS words, each taken by a store read
//  and then an output register before it is shown.
//  Reset (rst_n low, asynchronous) puts the parser in header hunt and empties
//  the queue; the word store needs no clearing pass. An output stall delays
//  the emitter and so can fill the queue and hold rx.ready low.
module pm_sensor_frame_parser_unit #(
    parameter int DATA_WORDS = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    pmsfp_byte_if.sink    rx,
    pmsfp_word_if.source  words,
    pmsfp_cfg_if.sink     cfg
);

    localparam int ADDR_W = $clog2(2 * DATA_WORDS);

    pmsfp_pkg::q_stat_t  q_stat;
    pmsfp_pkg::report_t  push_data;
    pmsfp_pkg::report_t  head;
    logic                push;
    logic                pop;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [15:0]         ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [15:0]         ram_rdata;

    pmsfp_front #(.DATA_WORDS(DATA_WORDS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    pmsfp_ram #(.WIDTH(16), .DEPTH(2 * DATA_WORDS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pmsfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    pmsfp_back #(.DATA_WORDS(DATA_WORDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid |-> (words.last_word == (words.word_index == 4'(DATA_WORDS - 1))))
        else $error("last_word does not match final word index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid |-> (words.word_index <= 4'(DATA_WORDS - 1)))
        else $error("word index out of range");

    a_valid_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid |-> !q_stat.empty)
        else $error("word presented with no queued report");

    a_gap_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (words.valid && words.ready && words.last_word) |=> !words.valid)
        else $error("word presented right after the final word of a frame");
`endif

endmodule

@@ sv/pmsfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pmsfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 26,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/pmsfp_queue.sv @@
// Two-entry report queue between the byte parser and the word emitter.
module pmsfp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pmsfp_pkg::report_t  push_data,
    input  logic                pop,
    output pmsfp_pkg::report_t  head,
    output pmsfp_pkg::q_stat_t  stat
);

    pmsfp_pkg::report_t entry_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

@@ sv/pmsfp_front.sv @@
// Byte parser: header hunt, checksum, word capture into the store, report throttle.
module pmsfp_front #(
    parameter int DATA_WORDS = 13,
    localparam int ADDR_W = $clog2(2 * DATA_WORDS)
) (
    input  logic                clk,
    input  logic                rst_n,
    pmsfp_byte_if.sink          rx,
    pmsfp_cfg_if.sink           cfg,
    input  pmsfp_pkg::q_stat_t  q_stat,
    output logic                push,
    output pmsfp_pkg::report_t  push_data,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [15:0]         ram_wdata
);

    localparam int FRAME_BYTES = 2 * DATA_WORDS + 4;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    logic             in_frame_reg, in_frame_next;
    logic [7:0]       prev_reg, prev_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       hold_reg, hold_next;
    logic [7:0]       cks_hi_reg, cks_hi_next;
    logic [31:0]      last_tick_reg, last_tick_next;
    logic             has_rep_reg, has_rep_next;
    logic             bank_reg, bank_next;
    logic [31:0]      interval_reg;

    logic             accept;
    logic [POS_W-1:0] off;
    logic             is_data;
    logic             is_cks_hi;
    logic [31:0]      elapsed;
    logic             pass;

    assign rx.ready  = !q_stat.full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;

    assign off       = pos_reg - POS_W'(2);
    assign is_data   = pos_reg < POS_W'(FRAME_BYTES - 2);
    assign is_cks_hi = pos_reg == POS_W'(FRAME_BYTES - 2);
    assign elapsed   = rx.tick_now - last_tick_reg;
    assign pass      = ({cks_hi_reg, rx.rx_byte} == sum_reg)
                       && (!has_rep_reg || elapsed >= interval_reg);

    // Odd data byte completes a word: store it in the bank being filled.
    assign ram_we    = accept && in_frame_reg && is_data && (pos_reg >= POS_W'(2)) && off[0];
    assign ram_waddr = ADDR_W'(bank_reg ? DATA_WORDS : 0) + ADDR_W'(off >> 1);
    assign ram_wdata = {hold_reg, rx.rx_byte};

    assign push           = accept && in_frame_reg && !is_data && !is_cks_hi && pass;
    assign push_data.bank = bank_reg;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        hold_next      = hold_reg;
        cks_hi_next    = cks_hi_reg;
        last_tick_next = last_tick_reg;
        has_rep_next   = has_rep_reg;
        bank_next      = bank_reg;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx.rx_byte == pmsfp_pkg::HDR_SECOND && prev_reg == pmsfp_pkg::HDR_FIRST)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = '0;
                    sum_next      = 16'(pmsfp_pkg::HDR_FIRST) + 16'(pmsfp_pkg::HDR_SECOND);
                end
                prev_next = rx.rx_byte;
            end
            else if (is_data)
            begin
                sum_next = sum_reg + 16'(rx.rx_byte);
                if (pos_reg >= POS_W'(2) && !off[0])
                begin
                    hold_next = rx.rx_byte;
                end
                pos_next = pos_reg + POS_W'(1);
            end
            else if (is_cks_hi)
            begin
                cks_hi_next = rx.rx_byte;
                pos_next    = pos_reg + POS_W'(1);
            end
            else
            begin
                // Frame ends: back to hunting, the trailing byte counts as the second header byte.
                in_frame_next = 1'b0;
                pos_next      = '0;
                prev_next     = pmsfp_pkg::HDR_SECOND;
                if (pass)
                begin
                    has_rep_next   = 1'b1;
                    last_tick_next = rx.tick_now;
                    bank_next      = ~bank_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            prev_reg      <= 8'd0;
            pos_reg       <= '0;
            sum_reg       <= 16'd0;
            hold_reg      <= 8'd0;
            cks_hi_reg    <= 8'd0;
            last_tick_reg <= 32'd0;
            has_rep_reg   <= 1'b0;
            bank_reg      <= 1'b0;
            interval_reg  <= pmsfp_pkg::REPORT_INTERVAL_RESET;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            hold_reg      <= hold_next;
            cks_hi_reg    <= cks_hi_next;
            last_tick_reg <= last_tick_next;
            has_rep_reg   <= has_rep_next;
            bank_reg      <= bank_next;
            if (cfg.valid && cfg.ready)
            begin
                interval_reg <= cfg.report_interval;
            end
        end
    end

endmodule

@@ sv/pmsfp_back.sv @@
// Word emitter: reads a reported frame's words from the store and presents them one by one.
module pmsfp_back #(
    parameter int DATA_WORDS = 13,
    localparam int ADDR_W = $clog2(2 * DATA_WORDS)
) (
    input  logic                clk,
    input  logic                rst_n,
    pmsfp_word_if.source        words,
    input  pmsfp_pkg::q_stat_t  q_stat,
    input  pmsfp_pkg::report_t  head,
    output logic                pop,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [15:0]         ram_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SHOW  = 2'd2;

    localparam logic [pmsfp_pkg::WORD_INDEX_W-1:0] LAST_IDX =
        pmsfp_pkg::WORD_INDEX_W'(DATA_WORDS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [pmsfp_pkg::WORD_INDEX_W-1:0]  idx_reg, idx_next;
    logic [15:0]                         value_reg, value_next;

    assign ram_raddr = ADDR_W'(head.bank ? DATA_WORDS : 0) + ADDR_W'(idx_next);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        ram_re     = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    idx_next   = '0;
                    ram_re     = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                value_next = ram_rdata;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (words.ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        // Release the bank only once its last word is gone.
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + pmsfp_pkg::WORD_INDEX_W'(1);
                        ram_re     = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign words.valid      = (state_reg == ST_SHOW);
    assign words.word_index = idx_reg;
    assign words.word_value = value_reg;
    assign words.last_word  = (idx_reg == LAST_IDX);

endmodule

@@ tb/pm_sensor_frame_parser_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the particulate sensor frame parser top level.
module pm_sensor_frame_parser_unit_test;

    localparam int DATA_WORDS   = 13;
    localparam int BODY_LEN     = 2 * DATA_WORDS + 4;
    localparam int PHASE_ITEMS  = 8;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [pmsfp_pkg::WORD_INDEX_W-1:0] widx;
        logic [pmsfp_pkg::WORD_W-1:0]       wval;
        logic                               wlast;
    } word_result_t;

    typedef enum {ROW_RAW, ROW_FRAME, ROW_BODY} row_kind_t;
    typedef enum {SEQ_GOOD, SEQ_BADSUM, SEQ_NOISE, SEQ_CUT, SEQ_BODY} seq_kind_t;
    typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  raw;
        logic [15:0] len;
        logic [15:0] fill;
        logic [15:0] step;
        logic [15:0] csum_flip;
        logic [31:0] tick;
        bit          typed;
        int          exp_count;
    } stim_row_t;

    // kind, raw, len, fill, step, csum_flip, tick, typed, exp_count
    stim_row_t directed_rows [13] = '{
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h0000, 16'h0000, 16'h0000, 32'd100,    1'b1, 13},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'hFFFF, 16'h0000, 16'h0000, 32'd200,    1'b1, 0},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h1234, 16'h0000, 16'h0001, 32'd40000,  1'b1, 0},
        '{ROW_FRAME, 8'h00, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 32'd15100,  1'b1, 13},
        '{ROW_RAW,   8'h4D, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd15200,  1'b0, 0},
        '{ROW_FRAME, 8'h00, 16'h0000, 16'h424D, 16'h0000, 16'h0000, 32'd30100,  1'b1, 13},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h8000, 16'h0001, 16'h0000, 32'hFFFFFFF0, 1'b0, 0},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h0001, 16'h1111, 16'h0000, 32'h00003000, 1'b0, 0},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h7FFF, 16'h0F0F, 16'h0000, 32'h00010000, 1'b0, 0},
        '{ROW_RAW,   8'h42, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00010004, 1'b0, 0},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'hA5A5, 16'h5A5A, 16'h0000, 32'h00020000, 1'b0, 0},
        '{ROW_FRAME, 8'h00, 16'h001C, 16'h0000, 16'h0101, 16'h8000, 32'h00030000, 1'b0, 0},
        '{ROW_BODY,  8'h00, 16'h001C, 16'h4D42, 16'h0000, 16'h0000, 32'h00040000, 1'b0, 0}
    };

    logic clk;
    logic rst_n;

    pmsfp_byte_if rx_ch ();
    pmsfp_word_if word_ch ();
    pmsfp_cfg_if  cfg_ch ();

    pm_sensor_frame_parser_unit #(
        .DATA_WORDS(DATA_WORDS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .words (word_ch),
        .cfg   (cfg_ch)
    );

    // Frame tracker: mirrors the parser state
    bit          syncd         = 1'b0;
    logic [7:0]  last_rx       = 8'h00;
    int          pos           = 0;
    logic [15:0] acc_sum       = 16'h0000;
    logic [7:0]  hi_byte       = 8'h00;
    logic [15:0] word_buf [DATA_WORDS];
    logic [15:0] got_sum       = 16'h0000;
    logic [31:0] report_tick   = 32'h0;
    bit          reported_once = 1'b0;
    logic [31:0] min_gap       = pmsfp_pkg::REPORT_INTERVAL_RESET;

    word_result_t expected_words [$];
    logic [7:0]   frame_bytes [$];
    logic [15:0]  frame_words [DATA_WORDS];
    logic [31:0]  cur_tick;
    int           burst_left;
    int           bytes_sent;
    int           mismatch_count;
    int           cycle_count;
    bit           hold_req;
    bit           hold_done;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Returns 1 when the byte completes a frame that is to be reported.
    function automatic bit track_frame_byte(input logic [7:0] b, input logic [31:0] now);
        bit fire;
        fire = 1'b0;
        if (!syncd)
        begin
            if (b == pmsfp_pkg::HDR_SECOND && last_rx == pmsfp_pkg::HDR_FIRST)
            begin
                syncd   = 1'b1;
                pos     = 0;
                acc_sum = 16'(pmsfp_pkg::HDR_FIRST) + 16'(pmsfp_pkg::HDR_SECOND);
            end
            last_rx = b;
        end
        else if (pos < BODY_LEN - 2)
        begin
            acc_sum = acc_sum + 16'(b);
            if (pos >= 2)
            begin
                if ((pos % 2) == 0)
                    hi_byte = b;
                else
                    word_buf[(pos - 2) / 2] = {hi_byte, b};
            end
            pos++;
        end
        else if (pos == BODY_LEN - 2)
        begin
            got_sum = {b, 8'h00};
            pos++;
        end
        else
        begin
            got_sum[7:0] = b;
            syncd   = 1'b0;
            pos     = 0;
            last_rx = pmsfp_pkg::HDR_SECOND;
            if (got_sum == acc_sum && (!reported_once || (now - report_tick) >= min_gap))
            begin
                reported_once = 1'b1;
                report_tick   = now;
                fire          = 1'b1;
            end
        end
        return fire;
    endfunction

    // Lay out frame_words as a frame in frame_bytes, with an optional header.
    function automatic void build_frame(input bit with_hdr, input logic [15:0] len,
                                        input logic [15:0] csum_flip);
        logic [15:0] sum;
        sum = 16'(pmsfp_pkg::HDR_FIRST) + 16'(pmsfp_pkg::HDR_SECOND);
        frame_bytes.delete();
        if (with_hdr)
        begin
            frame_bytes.push_back(pmsfp_pkg::HDR_FIRST);
            frame_bytes.push_back(pmsfp_pkg::HDR_SECOND);
        end
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        for (int k = 0; k < DATA_WORDS; k++)
        begin
            frame_bytes.push_back(frame_words[k][15:8]);
            frame_bytes.push_back(frame_words[k][7:0]);
        end
        for (int k = with_hdr ? 2 : 0; k < frame_bytes.size(); k++)
            sum = sum + 16'(frame_bytes[k]);
        sum = sum ^ csum_flip;
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
    endfunction

    // Offer one byte in bursts with random gaps; return at the edge of its transfer.
    task automatic send_byte(input logic [7:0] b, input int tick_step, input bit by_model);
        if (burst_left == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        rx_ch.valid    <= 1'b1;
        rx_ch.rx_byte  <= b;
        rx_ch.tick_now <= cur_tick;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
        if (track_frame_byte(b, cur_tick) && by_model)
        begin
            for (int k = 0; k < DATA_WORDS; k++)
                expected_words.push_back('{widx: 4'(k), wval: word_buf[k],
                                           wlast: (k == DATA_WORDS - 1)});
        end
        cur_tick = cur_tick + 32'($urandom_range(0, tick_step));
        if (tick_step > 0 && $urandom_range(0, 63) == 0)
            cur_tick = $urandom();
    endtask

    task automatic send_frame_bytes(input int count, input int tick_step, input bit by_model);
        for (int k = 0; k < count && k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], tick_step, by_model);
    endtask

    task automatic send_random_sequence(input bit force_good, input int tick_step);
        seq_kind_t   kind;
        int          r;
        logic [7:0]  b;
        logic [15:0] len;
        r    = $urandom_range(0, 9);
        kind = (force_good || r < 6) ? SEQ_GOOD : seq_kind_t'(r - 5);
        len  = $urandom_range(0, 1) ? 16'h001C : 16'($urandom());
        for (int k = 0; k < DATA_WORDS; k++)
        begin
            case ($urandom_range(0, 7))
                0: frame_words[k] = 16'h0000;
                1: frame_words[k] = 16'hFFFF;
                2: frame_words[k] = {pmsfp_pkg::HDR_FIRST, pmsfp_pkg::HDR_SECOND};
                default: frame_words[k] = 16'($urandom());
            endcase
        end
        case (kind)
            SEQ_GOOD:
            begin
                build_frame(1'b1, len, 16'h0000);
                send_frame_bytes(frame_bytes.size(), tick_step, 1'b1);
            end
            SEQ_BADSUM:
            begin
                build_frame(1'b1, len, 16'($urandom_range(1, 65535)));
                send_frame_bytes(frame_bytes.size(), tick_step, 1'b1);
            end
            SEQ_NOISE:
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 2) == 0)
                        b = $urandom_range(0, 1) ? pmsfp_pkg::HDR_FIRST
                                                 : pmsfp_pkg::HDR_SECOND;
                    else
                        b = 8'($urandom());
                    send_byte(b, tick_step, 1'b1);
                end
            end
            SEQ_CUT:
            begin
                // drop the tail; the next sequence lands inside this frame
                build_frame(1'b1, len, 16'h0000);
                send_frame_bytes(2 + $urandom_range(1, BODY_LEN - 1), tick_step, 1'b1);
            end
            default:
            begin
                build_frame(1'b0, len, 16'h0000);
                send_frame_bytes(frame_bytes.size(), tick_step, 1'b1);
            end
        endcase
    endtask

    // Write the interval only once the parser has gone quiet.
    task automatic write_interval(input logic [31:0] value);
        rx_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.report_interval <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        min_gap = value;
    endtask

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        word_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                word_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RDY_ALWAYS: word_ch.ready <= 1'b1;
                    RDY_MOSTLY: word_ch.ready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY: word_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:    word_ch.ready <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        word_result_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: word_index %0d word_value %h last_word %b",
                       word_ch.word_index, word_ch.word_value, word_ch.last_word);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (word_ch.word_index !== want.widx)
                begin
                    $error("word_index: expected %0d, actual %0d", want.widx,
                           word_ch.word_index);
                    mismatch_count++;
                end
                if (word_ch.word_value !== want.wval)
                begin
                    $error("word_value: expected %h, actual %h", want.wval,
                           word_ch.word_value);
                    mismatch_count++;
                end
                if (word_ch.last_word !== want.wlast)
                begin
                    $error("last_word: expected %b, actual %b", want.wlast,
                           word_ch.last_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t   row;
        logic [31:0] phase_interval [NUM_PHASES];
        int          phase_start;
        int          tick_step;
        mismatch_count = 0;
        bytes_sent     = 0;
        burst_left     = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        cur_tick       = 32'h0;
        rst_n          = 1'b0;
        rx_ch.valid            <= 1'b0;
        rx_ch.rx_byte          <= 8'h00;
        rx_ch.tick_now         <= 32'h0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.report_interval <= 32'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row      = directed_rows[i];
            cur_tick = row.tick;
            if (row.kind == ROW_RAW)
                send_byte(row.raw, 0, 1'b1);
            else
            begin
                for (int k = 0; k < DATA_WORDS; k++)
                    frame_words[k] = 16'(row.fill + 16'(k) * row.step);
                build_frame(row.kind == ROW_FRAME, row.len, row.csum_flip);
                send_frame_bytes(frame_bytes.size(), 0, !row.typed);
                if (row.typed)
                begin
                    for (int k = 0; k < row.exp_count; k++)
                        expected_words.push_back('{widx: 4'(k), wval: row.fill,
                                                   wlast: (k == DATA_WORDS - 1)});
                end
            end
        end

        phase_interval[0] = 32'h0;
        phase_interval[1] = 32'hFFFF_FFFF;
        phase_interval[2] = 32'h1;
        phase_interval[3] = $urandom_range(100, 5000);
        phase_interval[4] = $urandom();
        phase_interval[5] = pmsfp_pkg::REPORT_INTERVAL_RESET;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_interval(phase_interval[ph]);
            tick_step = $urandom_range(0, 600);
            if (ph == 0)
            begin
                // stall the receiver and keep the sender busy until the queue fills
                hold_req   = 1'b1;
                burst_left = 1000;
                repeat (3) send_random_sequence(1'b1, tick_step);
                burst_left = 0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
                send_random_sequence(1'b0, tick_step);
        end

        rx_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pmsfp_pkg.sv
sv/pmsfp_if.sv
sv/pmsfp_ram.sv
sv/pmsfp_queue.sv
sv/pmsfp_front.sv
sv/pmsfp_back.sv
sv/pm_sensor_frame_parser_unit.sv
tb/pm_sensor_frame_parser_unit_test.sv
